// ----- rtl/core/rbm_pkg.sv -----
// Shared types and constants for the modular exponentiation engine.
`default_nettype none

package rbm_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int WORD_WIDTH      = 32;
   localparam int EXP_WIDTH       = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [BYTE_WIDTH-1:0] BYTE_MASK = 8'hFF;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENC_EXP = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEC_EXP = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS = 2'd2;

   localparam logic [EXP_WIDTH-1:0]  ENC_EXP_RESET = 32'd1;
   localparam logic [EXP_WIDTH-1:0]  DEC_EXP_RESET = 32'd1;
   localparam logic [WORD_WIDTH-1:0] MODULUS_RESET = 32'hFFFF_FFFF;

   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   typedef struct packed {
      logic [EXP_WIDTH-1:0]  enc_exp;
      logic [EXP_WIDTH-1:0]  dec_exp;
      logic [WORD_WIDTH-1:0] modulus;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mm_stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/rbm_channels.sv -----
// Valid/ready channel interfaces: request, response and register write.
`default_nettype none

interface rbm_req_if;
   import rbm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [BYTE_WIDTH-1:0] byte_hi;
   logic [BYTE_WIDTH-1:0] byte_mid;
   logic [BYTE_WIDTH-1:0] byte_lo;
   logic [1:0]            byte_count;
   logic [WORD_WIDTH-1:0] cipher_in;
   logic                  last_in;

   modport source (output valid, func, byte_hi, byte_mid, byte_lo, byte_count, cipher_in,
                   last_in, input ready);
   modport sink (input valid, func, byte_hi, byte_mid, byte_lo, byte_count, cipher_in,
                 last_in, output ready);
endinterface

interface rbm_rsp_if;
   import rbm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] cipher_out;
   logic [BYTE_WIDTH-1:0] plain_hi;
   logic [BYTE_WIDTH-1:0] plain_mid;
   logic [BYTE_WIDTH-1:0] plain_lo;
   logic                  last_out;

   modport source (output valid, cipher_out, plain_hi, plain_mid, plain_lo, last_out,
                   input ready);
   modport sink (input valid, cipher_out, plain_hi, plain_mid, plain_lo, last_out,
                 output ready);
endinterface

interface rbm_csr_if;
   import rbm_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [WORD_WIDTH-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rbm_csr.sv -----
// Configuration registers: exponents and modulus.
`default_nettype none

module rbm_csr (
   input  wire logic      clock,
   input  wire logic      reset,
   rbm_csr_if.sink        csr_ch,
   output rbm_pkg::cfg_type cfg
);
   import rbm_pkg::*;

   cfg_type cfg_ff;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enc_exp <= ENC_EXP_RESET;
         cfg_ff.dec_exp <= DEC_EXP_RESET;
         cfg_ff.modulus <= MODULUS_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_ENC_EXP: cfg_ff.enc_exp <= csr_ch.data;
            CSR_DEC_EXP: cfg_ff.dec_exp <= csr_ch.data;
            CSR_MODULUS: cfg_ff.modulus <= csr_ch.data;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/rbm_modmul.sv -----
// Bit-serial interleaved modular multiplier, one operand bit per cycle.
`default_nettype none

module rbm_modmul #(
   parameter int W = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [rbm_pkg::WORD_WIDTH-1:0] a,
   input  wire logic [W-1:0]              b,
   input  wire logic [W-1:0]              m,
   output rbm_pkg::mm_stat_type           stat,
   output logic [W-1:0]                   result
);
   import rbm_pkg::*;

   localparam int CW = $clog2(WORD_WIDTH);
   localparam logic [CW-1:0] LAST_BIT = CW'(WORD_WIDTH - 1);

   logic [WORD_WIDTH-1:0] a_ff;
   logic [W-1:0]          b_ff;
   logic [W-1:0]          r_ff;
   logic [W-1:0]          r_in;
   logic [CW-1:0]         cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic [W:0] m_ext;
   logic [W:0] dbl;
   logic [W:0] dbl_red;
   logic [W:0] addend;
   logic [W:0] sum;
   logic [W:0] sum_red;

   // r = 2r + a_bit*b, reduced twice; r stays below m
   always_comb begin
      m_ext   = {1'b0, m};
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
      addend  = a_ff[WORD_WIDTH-1] ? {1'b0, b_ff} : '0;
      sum     = {1'b0, dbl_red[W-1:0]} + addend;
      sum_red = (sum >= m_ext) ? sum - m_ext : sum;
      r_in    = sum_red[W-1:0];
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == LAST_BIT);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_BIT) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         b_ff <= b;
         r_ff <= '0;
      end else if (busy_ff) begin
         a_ff <= {a_ff[WORD_WIDTH-2:0], 1'b0};
         r_ff <= r_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/rsa_block_modexp.sv -----
// Top level: toy RSA modular exponentiation engine with serial multiplier.
// Channels: req_ch takes one item per beat (func, plaintext bytes with
// byte_count, cipher_in, last_in); rsp_ch returns one beat per item with
// cipher_out (encrypt) or plain_hi/mid/lo (decrypt) and last_out.
// csr_ch writes encrypt_exponent (0), decrypt_exponent (1), modulus (2);
// csr_ch.ready is always high, other indexes are dropped.
// One item at a time. The input is first reduced modulo the modulus, then
// right-to-left square-and-multiply runs on one bit-serial multiplier; the
// steps are the reduction, then a multiply for each set exponent bit and a
// square for each bit below the top set bit. A zero exponent goes straight
// from the reduction to the result. A modulus of zero (in its low MOD_WIDTH
// bits) skips the multiplier, and the result is zero.
// The result waits in an output register; a new request is taken while it
// waits, and a finished product waits for the register if rsp_ch stalls.
// Reset (synchronous) idles the engine, drops a pending result and restores
// exponents to 1 and the modulus to all ones.
`default_nettype none

module rsa_block_modexp #(
   parameter int MOD_WIDTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   rbm_req_if.sink   req_ch,
   rbm_rsp_if.source rsp_ch,
   rbm_csr_if.sink   csr_ch
);
   import rbm_pkg::*;

   localparam int W = MOD_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RED,
      S_MUL,
      S_SQR,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      OP_RED,
      OP_MUL,
      OP_SQR
   } op_type;

   cfg_type     cfg;
   mm_stat_type mm_stat;
   logic [W-1:0] mm_result;

   state_type             state_ff;
   op_type                op_ff;
   logic                  start_ff;
   logic                  start_in;
   logic [WORD_WIDTH-1:0] src_ff;
   logic [W-1:0]          acc_ff;
   logic [W-1:0]          base_ff;
   logic [EXP_WIDTH-1:0]  exp_ff;
   logic [W-1:0]          m_ff;
   logic                  func_ff;
   logic                  last_ff;

   logic                  rsp_valid_ff;
   logic [WORD_WIDTH-1:0] cipher_out_ff;
   logic [BYTE_WIDTH-1:0] plain_hi_ff;
   logic [BYTE_WIDTH-1:0] plain_mid_ff;
   logic [BYTE_WIDTH-1:0] plain_lo_ff;
   logic                  last_out_ff;

   logic [WORD_WIDTH-1:0] mm_a;
   logic [W-1:0]          mm_b;
   logic [W-1:0]          m_in;
   logic [WORD_WIDTH-1:0] pt_in;
   logic [WORD_WIDTH-1:0] acc_word;
   logic [EXP_WIDTH-1:0]  exp_shift;
   logic                  accept;
   logic                  out_load;

   rbm_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   rbm_modmul #(.W(W)) u_modmul (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .a      (mm_a),
      .b      (mm_b),
      .m      (m_ff),
      .stat   (mm_stat),
      .result (mm_result)
   );

   always_comb begin
      case (op_ff)
         OP_RED: begin
            mm_a = src_ff;
            mm_b = W'(1);
         end
         OP_MUL: begin
            mm_a = WORD_WIDTH'(acc_ff);
            mm_b = base_ff;
         end
         OP_SQR: begin
            mm_a = WORD_WIDTH'(base_ff);
            mm_b = base_ff;
         end
         default: begin
            mm_a = '0;
            mm_b = '0;
         end
      endcase
   end

   always_comb begin
      m_in = cfg.modulus[W-1:0];
      case (req_ch.byte_count)
         2'd1:    pt_in = {8'd0, req_ch.byte_hi, 16'd0};
         2'd2:    pt_in = {8'd0, req_ch.byte_hi, req_ch.byte_mid, 8'd0};
         default: pt_in = {8'd0, req_ch.byte_hi, req_ch.byte_mid, req_ch.byte_lo};
      endcase
      acc_word  = WORD_WIDTH'(acc_ff);
      exp_shift = exp_ff >> 1;
      case (state_ff)
         S_IDLE:  start_in = accept && (m_in != '0);
         S_RED:   start_in = mm_stat.done && (exp_ff != '0);
         S_MUL:   start_in = mm_stat.done && (exp_shift != '0);
         S_SQR:   start_in = mm_stat.done;
         default: start_in = 1'b0;
      endcase
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_load     = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cipher_out = cipher_out_ff;
   assign rsp_ch.plain_hi   = plain_hi_ff;
   assign rsp_ch.plain_mid  = plain_mid_ff;
   assign rsp_ch.plain_lo   = plain_lo_ff;
   assign rsp_ch.last_out   = last_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_RED;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= start_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  m_ff    <= m_in;
                  func_ff <= req_ch.func;
                  last_ff <= req_ch.last_in;
                  src_ff  <= (req_ch.func == FUNC_DECRYPT) ? req_ch.cipher_in : pt_in;
                  exp_ff  <= (req_ch.func == FUNC_DECRYPT) ? cfg.dec_exp : cfg.enc_exp;
                  acc_ff  <= (m_in <= W'(1)) ? '0 : W'(1);
                  if (m_in == '0) begin
                     state_ff <= S_OUT;
                  end else begin
                     op_ff    <= OP_RED;
                     state_ff <= S_RED;
                  end
               end
            end
            S_RED: begin
               if (mm_stat.done) begin
                  base_ff <= mm_result;
                  if (exp_ff == '0) begin
                     state_ff <= S_OUT;
                  end else if (exp_ff[0]) begin
                     op_ff    <= OP_MUL;
                     state_ff <= S_MUL;
                  end else begin
                     op_ff    <= OP_SQR;
                     state_ff <= S_SQR;
                  end
               end
            end
            S_MUL: begin
               if (mm_stat.done) begin
                  acc_ff <= mm_result;
                  if (exp_shift == '0) begin
                     state_ff <= S_OUT;
                  end else begin
                     op_ff    <= OP_SQR;
                     state_ff <= S_SQR;
                  end
               end
            end
            S_SQR: begin
               if (mm_stat.done) begin
                  base_ff <= mm_result;
                  exp_ff  <= exp_shift;
                  if (exp_shift[0]) begin
                     op_ff    <= OP_MUL;
                     state_ff <= S_MUL;
                  end else begin
                     op_ff    <= OP_SQR;
                     state_ff <= S_SQR;
                  end
               end
            end
            S_OUT: begin
               if (out_load) begin
                  last_out_ff <= last_ff;
                  if (func_ff == FUNC_DECRYPT) begin
                     cipher_out_ff <= '0;
                     plain_hi_ff   <= acc_word[23:16] & BYTE_MASK;
                     plain_mid_ff  <= acc_word[15:8] & BYTE_MASK;
                     plain_lo_ff   <= acc_word[7:0] & BYTE_MASK;
                  end else begin
                     cipher_out_ff <= acc_word;
                     plain_hi_ff   <= '0;
                     plain_mid_ff  <= '0;
                     plain_lo_ff   <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_start_idle_mm: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> !mm_stat.busy)
      else $error("multiplier started while busy");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && m_ff != '0) |-> (acc_ff < m_ff))
      else $error("accumulator not reduced");

   a_sqr_needed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQR) |-> (exp_shift != '0))
      else $error("squaring with no exponent bits left");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside output state");

endmodule

`default_nettype wire

// ----- tb/rsa_block_modexp_tb.sv -----
`timescale 1ns / 100ps
// Testbench for rsa_block_modexp: random and directed beats against a modular power model.
module rsa_block_modexp_tb;
   import rbm_pkg::*;

   localparam int MOD_WIDTH       = 32;
   localparam int CLK_PERIOD      = 20;
   localparam int RESET_CYCLES    = 5;
   localparam int DRAIN_CYCLES    = 64;
   localparam int TIMEOUT_NS      = 60_000_000;
   localparam int BEATS_PER_PHASE = 26;
   localparam int RANDOM_PHASES   = 10;
   localparam int MAX_REPORTS     = 100;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam logic [63:0] MOD_MASK =
      (MOD_WIDTH >= 32) ? 64'hFFFF_FFFF : (64'd1 << MOD_WIDTH) - 64'd1;
   localparam int SEND_IDLE_PCT[4]  = '{0, 65, 0, 36};
   localparam int RECV_STALL_PCT[4] = '{0, 0, 65, 36};

   typedef struct packed {
      logic                  func;
      logic [BYTE_WIDTH-1:0] byte_hi;
      logic [BYTE_WIDTH-1:0] byte_mid;
      logic [BYTE_WIDTH-1:0] byte_lo;
      logic [1:0]            byte_count;
      logic [WORD_WIDTH-1:0] cipher_in;
      logic                  last_in;
   } req_beat_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] cipher_out;
      logic [BYTE_WIDTH-1:0] plain_hi;
      logic [BYTE_WIDTH-1:0] plain_mid;
      logic [BYTE_WIDTH-1:0] plain_lo;
      logic                  last_out;
   } rsp_beat_type;

   logic clock;
   logic reset;

   rbm_req_if req_if ();
   rbm_rsp_if rsp_if ();
   rbm_csr_if csr_if ();

   rsa_block_modexp #(
      .MOD_WIDTH(MOD_WIDTH)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_ch(csr_if)
   );

   req_beat_type send_q[$];
   rsp_beat_type result_q[$];
   req_beat_type cur_beat;
   rsp_beat_type want;
   cfg_type      shadow_cfg;
   int           queued_count;
   int           accepted_count;
   int           error_count;
   int           send_idle_pct;
   int           recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [WORD_WIDTH-1:0] mod_power(input logic [WORD_WIDTH-1:0] base_in,
                                                       input logic [EXP_WIDTH-1:0] exp_in);
      logic [63:0]          m;
      logic [63:0]          acc;
      logic [63:0]          b;
      logic [EXP_WIDTH-1:0] e;
      m = {32'h0, shadow_cfg.modulus} & MOD_MASK;
      if (m == 64'd0) begin
         return '0;
      end
      acc = 64'd1 % m;
      b   = {32'h0, base_in} % m;
      e   = exp_in;
      while (e != '0) begin
         if (e[0]) begin
            acc = (acc * b) % m;
         end
         b = (b * b) % m;
         e = e >> 1;
      end
      return acc[WORD_WIDTH-1:0];
   endfunction

   function automatic rsp_beat_type predict_result(input req_beat_type b);
      rsp_beat_type          r;
      logic [WORD_WIDTH-1:0] plain;
      logic [WORD_WIDTH-1:0] k;
      r = '0;
      r.last_out = b.last_in;
      if (b.func == FUNC_ENCRYPT) begin
         plain = {8'h00, b.byte_hi, 16'h0000};
         if (b.byte_count != 2'd1) begin
            plain[15:8] = b.byte_mid;
         end
         // a count of zero packs all three bytes
         if (b.byte_count == 2'd3 || b.byte_count == 2'd0) begin
            plain[7:0] = b.byte_lo;
         end
         r.cipher_out = mod_power(plain, shadow_cfg.enc_exp);
      end else begin
         k = mod_power(b.cipher_in, shadow_cfg.dec_exp);
         r.plain_hi  = k[23:16];
         r.plain_mid = k[15:8];
         r.plain_lo  = k[7:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_WIDTH-1:0] got,
                                  input logic [WORD_WIDTH-1:0] exp_val);
      if (error_count < MAX_REPORTS) begin
         $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
      end
      error_count++;
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            result_q.push_back(predict_result(cur_beat));
            accepted_count++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_beat = send_q.pop_front();
               req_if.func       <= cur_beat.func;
               req_if.byte_hi    <= cur_beat.byte_hi;
               req_if.byte_mid   <= cur_beat.byte_mid;
               req_if.byte_lo    <= cur_beat.byte_lo;
               req_if.byte_count <= cur_beat.byte_count;
               req_if.cipher_in  <= cur_beat.cipher_in;
               req_if.last_in    <= cur_beat.last_in;
               req_if.valid      <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (result_q.size() == 0) begin
               report_mismatch("unexpected beat, cipher_out", rsp_if.cipher_out, '0);
            end else begin
               want = result_q.pop_front();
               if (rsp_if.cipher_out !== want.cipher_out) begin
                  report_mismatch("cipher_out", rsp_if.cipher_out, want.cipher_out);
               end
               if (rsp_if.plain_hi !== want.plain_hi) begin
                  report_mismatch("plain_hi", WORD_WIDTH'(rsp_if.plain_hi),
                                  WORD_WIDTH'(want.plain_hi));
               end
               if (rsp_if.plain_mid !== want.plain_mid) begin
                  report_mismatch("plain_mid", WORD_WIDTH'(rsp_if.plain_mid),
                                  WORD_WIDTH'(want.plain_mid));
               end
               if (rsp_if.plain_lo !== want.plain_lo) begin
                  report_mismatch("plain_lo", WORD_WIDTH'(rsp_if.plain_lo),
                                  WORD_WIDTH'(want.plain_lo));
               end
               if (rsp_if.last_out !== want.last_out) begin
                  report_mismatch("last_out", WORD_WIDTH'(rsp_if.last_out),
                                  WORD_WIDTH'(want.last_out));
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic queue_beat(input req_beat_type b);
      send_q.push_back(b);
      queued_count++;
   endtask

   task automatic wait_idle();
      while (accepted_count != queued_count || result_q.size() != 0) @(posedge clock);
   endtask

   // Writes all three registers plus one write to the unused index
   task automatic write_config(input logic [EXP_WIDTH-1:0] enc, input logic [EXP_WIDTH-1:0] dec,
                               input logic [WORD_WIDTH-1:0] modv);
      logic [CSR_INDEX_WIDTH-1:0] idx[4];
      logic [WORD_WIDTH-1:0]      val[4];
      idx = '{CSR_ENC_EXP, CSR_DEC_EXP, CSR_UNUSED, CSR_MODULUS};
      val = '{enc, dec, $urandom(), modv};
      for (int k = 0; k < 4; k++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= idx[k];
         csr_if.data  <= val[k];
         @(posedge clock);
         while (!csr_if.ready) @(posedge clock);
         case (idx[k])
            CSR_ENC_EXP: shadow_cfg.enc_exp = val[k];
            CSR_DEC_EXP: shadow_cfg.dec_exp = val[k];
            CSR_MODULUS: shadow_cfg.modulus = val[k];
            default: ;
         endcase
      end
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_idle_mode(input int mode);
      send_idle_pct  = SEND_IDLE_PCT[mode];
      recv_stall_pct = RECV_STALL_PCT[mode];
   endtask

   function automatic logic [BYTE_WIDTH-1:0] pick_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return BYTE_WIDTH'($urandom());
      endcase
   endfunction

   // Unused fields carry random values; the block must ignore them
   function automatic req_beat_type enc_beat(input logic [BYTE_WIDTH-1:0] hi,
                                             input logic [BYTE_WIDTH-1:0] mid,
                                             input logic [BYTE_WIDTH-1:0] lo,
                                             input logic [1:0] cnt, input logic last);
      req_beat_type b;
      b.func       = FUNC_ENCRYPT;
      b.byte_hi    = hi;
      b.byte_mid   = mid;
      b.byte_lo    = lo;
      b.byte_count = cnt;
      b.cipher_in  = $urandom();
      b.last_in    = last;
      return b;
   endfunction

   function automatic req_beat_type dec_beat(input logic [WORD_WIDTH-1:0] word,
                                             input logic last);
      req_beat_type b;
      b.func       = FUNC_DECRYPT;
      b.byte_hi    = BYTE_WIDTH'($urandom());
      b.byte_mid   = BYTE_WIDTH'($urandom());
      b.byte_lo    = BYTE_WIDTH'($urandom());
      b.byte_count = 2'($urandom_range(3));
      b.cipher_in  = word;
      b.last_in    = last;
      return b;
   endfunction

   function automatic req_beat_type random_beat();
      logic [WORD_WIDTH-1:0] word;
      logic [1:0]            cnt;
      logic                  last;
      last = 1'($urandom_range(1));
      if ($urandom_range(1) == 0) begin
         cnt = ($urandom_range(9) == 0) ? 2'd0 : 2'($urandom_range(3, 1));
         return enc_beat(pick_byte(), pick_byte(), pick_byte(), cnt, last);
      end
      case ($urandom_range(5))
         0:       word = '0;
         1:       word = '1;
         2:       word = shadow_cfg.modulus - 32'd1;
         3:       word = (shadow_cfg.modulus != '0) ? $urandom() % shadow_cfg.modulus : '0;
         default: word = $urandom();
      endcase
      return dec_beat(word, last);
   endfunction

   function automatic logic [EXP_WIDTH-1:0] random_exponent(input bit full);
      int                   w;
      logic [EXP_WIDTH-1:0] e;
      w = full ? EXP_WIDTH : $urandom_range(12, 1);
      e = $urandom();
      if (w < EXP_WIDTH) begin
         e = e & ((32'd1 << w) - 32'd1);
      end
      if ($urandom_range(9) == 0) begin
         e = '0;
      end
      return e;
   endfunction

   function automatic logic [WORD_WIDTH-1:0] random_modulus();
      case ($urandom_range(4))
         0:       return $urandom_range(255, 1);
         1:       return 32'hFFFF_FFFF;
         2:       return {1'b1, 31'($urandom())};
         3:       return $urandom_range(65535, 2);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      reset            = 1'b1;
      req_if.valid      = 1'b0;
      req_if.func       = FUNC_ENCRYPT;
      req_if.byte_hi    = '0;
      req_if.byte_mid   = '0;
      req_if.byte_lo    = '0;
      req_if.byte_count = 2'd1;
      req_if.cipher_in  = '0;
      req_if.last_in    = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = CSR_ENC_EXP;
      csr_if.data       = '0;
      shadow_cfg        = '{enc_exp: ENC_EXP_RESET, dec_exp: DEC_EXP_RESET,
                            modulus: MODULUS_RESET};
      queued_count      = 0;
      accepted_count    = 0;
      error_count       = 0;
      set_idle_mode(0);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: identity exponent, all-ones modulus; byte packing and counts
      queue_beat(enc_beat(8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b0));
      queue_beat(enc_beat(8'h00, 8'h00, 8'h00, 2'd1, 1'b0));
      queue_beat(enc_beat(8'hFF, 8'hFF, 8'hFF, 2'd1, 1'b1));
      queue_beat(enc_beat(8'hFF, 8'hFF, 8'hFF, 2'd2, 1'b0));
      queue_beat(enc_beat(8'h12, 8'h34, 8'h56, 2'd0, 1'b1));
      queue_beat(dec_beat(32'h0000_0000, 1'b0));
      queue_beat(dec_beat(32'hFFFF_FFFF, 1'b1));
      queue_beat(dec_beat(32'hFFFF_FFFE, 1'b0));
      wait_idle();

      // zero exponent with modulus one
      write_config('0, '0, 32'd1);
      queue_beat(enc_beat(8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b1));
      queue_beat(dec_beat(32'hFFFF_FFFF, 1'b0));
      wait_idle();

      // zero exponent
      write_config('0, '0, 32'hFFFF_FFFF);
      queue_beat(enc_beat(8'h00, 8'h00, 8'h00, 2'd1, 1'b0));
      queue_beat(dec_beat(32'h0000_0000, 1'b1));
      wait_idle();

      // modulus zero
      write_config('1, '1, '0);
      queue_beat(enc_beat(8'hA5, 8'h5A, 8'hC3, 2'd3, 1'b0));
      queue_beat(dec_beat(32'hDEAD_BEEF, 1'b1));
      wait_idle();

      // largest exponents
      write_config('1, '1, 32'hFFFF_FFFF);
      queue_beat(enc_beat(8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b1));
      queue_beat(dec_beat(32'hFFFF_FFFE, 1'b0));
      queue_beat(dec_beat(32'h1234_5678, 1'b1));
      wait_idle();

      write_config(32'd65537, $urandom(), 32'd1);
      queue_beat(enc_beat(8'h80, 8'h01, 8'h7F, 2'd2, 1'b0));
      queue_beat(dec_beat(32'h8000_0001, 1'b1));
      wait_idle();

      write_config(32'd3, $urandom(), 32'hFFFF_FFFB);
      queue_beat(enc_beat(8'h7F, 8'h80, 8'h01, 2'd3, 1'b0));
      queue_beat(dec_beat(32'hFFFF_FFFA, 1'b1));
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_idle_mode(p % 4);
         write_config(random_exponent(p == 5), random_exponent(p == 5), random_modulus());
         for (int i = 0; i < BEATS_PER_PHASE; i++) begin
            // hold off the sender once until the block drains
            if (p == 2 && i == BEATS_PER_PHASE / 2) begin
               wait_idle();
            end
            queue_beat(random_beat());
         end
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/rbm_pkg.sv
rtl/core/rbm_channels.sv
rtl/core/rbm_csr.sv
rtl/core/rbm_modmul.sv
rtl/core/rsa_block_modexp.sv
tb/rsa_block_modexp_tb.sv
